// ----- design/deq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions for the double-ended queue
// Defaults, operation and status codes, field widths and the result word.
// ----------------------------------------------------------------------------

package deq_pkg;

	// default geometry
	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;

	// fixed field widths of the channels
	localparam int OP_W    = 3;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 4;
	localparam int COUNT_W = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	// one result word
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [VAL_W-1:0]   value_out;
		logic [IDX_W-1:0]   found_index;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
	} res_t;

endpackage

// ----- design/deq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_if: command and response channels of the double-ended queue
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------

interface deq_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [deq_pkg::OP_W-1:0]  opcode;
	logic [deq_pkg::VAL_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface deq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [deq_pkg::STAT_W-1:0]  status;
	logic [deq_pkg::VAL_W-1:0]   value_out;
	logic [deq_pkg::IDX_W-1:0]   found_index;
	logic [deq_pkg::COUNT_W-1:0] count;
	logic                        is_empty;

	modport source (output valid, output status, output value_out, output found_index,
		output count, output is_empty, input ready);
	modport sink   (input valid, input status, input value_out, input found_index,
		input count, input is_empty, output ready);
endinterface

// ----- design/deq_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_mem: ring storage of the queue
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------

module deq_mem #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	parameter int WIDTH = deq_pkg::WIDTH_DEF,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [PTR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [PTR_W-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/deq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl: queue sequencer
// Keeps head and count, drives the storage through one shared slot adder
// and one compare unit, and walks the entries one per cycle on a search.
// ----------------------------------------------------------------------------

module deq_ctrl #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	parameter int WIDTH = deq_pkg::WIDTH_DEF,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// command side
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  logic [deq_pkg::OP_W-1:0]  opcode,
	input  logic [deq_pkg::VAL_W-1:0] value,
	// result side
	output logic                      res_valid,
	input  logic                      res_ready,
	output deq_pkg::res_t             res,
	// storage side
	output logic                      wr_en,
	output logic [PTR_W-1:0]          wr_addr,
	output logic [WIDTH-1:0]          wr_data,
	output logic                      rd_en,
	output logic [PTR_W-1:0]          rd_addr,
	input  logic [WIDTH-1:0]          rd_data
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WAIT = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]                  state_q;
	logic [PTR_W-1:0]            head_q;
	logic [CNT_W-1:0]            occ_q;
	logic [PTR_W-1:0]            idx_q;
	logic [WIDTH-1:0]            target_q;
	logic [WIDTH-1:0]            popped_q;
	logic [deq_pkg::STAT_W-1:0]  status_q;
	logic [PTR_W-1:0]            found_q;

	logic             accept;
	logic             is_full;
	logic             is_empty;
	logic [CNT_W-1:0] offset;
	logic [SUM_W-1:0] sum;
	logic [PTR_W-1:0] slot;
	logic [CNT_W-1:0] idx_next;
	logic             hit;
	logic             last;
	logic [WIDTH-1:0] word;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign is_full   = (occ_q == CNT_W'(DEPTH));
	assign is_empty  = (occ_q == '0);
	assign word      = WIDTH'(value);
	assign idx_next  = CNT_W'(idx_q) + CNT_W'(1);

	// shared compare unit
	assign hit  = (rd_data == target_q);
	assign last = (idx_next == occ_q);

	// offset from the head for the shared slot adder
	always_comb begin
		offset = '0;
		if (state_q == S_IDLE) begin
			case (opcode)
				deq_pkg::OP_PUSH_FRONT: offset = CNT_W'(DEPTH - 1);
				deq_pkg::OP_PUSH_REAR:  offset = occ_q;
				deq_pkg::OP_POP_REAR:   offset = occ_q - CNT_W'(1);
				default:                offset = '0;
			endcase
		end else begin
			offset = idx_next;
		end
	end

	// shared slot adder with ring wrap
	assign sum  = SUM_W'(head_q) + SUM_W'(offset);
	assign slot = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);

	// storage requests
	always_comb begin
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		wr_addr = slot;
		rd_addr = slot;
		wr_data = word;
		if (accept) begin
			case (opcode)
				deq_pkg::OP_PUSH_FRONT,
				deq_pkg::OP_PUSH_REAR:  wr_en = !is_full;
				deq_pkg::OP_POP_FRONT,
				deq_pkg::OP_POP_REAR,
				deq_pkg::OP_SEARCH:     rd_en = !is_empty;
				default:                rd_en = 1'b0;
			endcase
		end else if (state_q == S_SCAN) begin
			rd_en = !hit && !last;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (opcode)
							deq_pkg::OP_PUSH_FRONT: begin
								state_q <= S_DONE;
								if (!is_full) begin
									head_q <= slot;
									occ_q  <= occ_q + CNT_W'(1);
								end
							end
							deq_pkg::OP_PUSH_REAR: begin
								state_q <= S_DONE;
								if (!is_full) begin
									occ_q <= occ_q + CNT_W'(1);
								end
							end
							deq_pkg::OP_POP_FRONT: begin
								if (is_empty) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_WAIT;
									head_q  <= (head_q == PTR_W'(DEPTH - 1)) ? '0
										: head_q + PTR_W'(1);
									occ_q   <= occ_q - CNT_W'(1);
								end
							end
							deq_pkg::OP_POP_REAR: begin
								if (is_empty) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_WAIT;
									occ_q   <= occ_q - CNT_W'(1);
								end
							end
							deq_pkg::OP_SEARCH: begin
								state_q <= is_empty ? S_DONE : S_SCAN;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WAIT: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (hit || last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result fields and search context
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= '0;
			found_q  <= '0;
			idx_q    <= '0;
			target_q <= word;
			case (opcode)
				deq_pkg::OP_PUSH_FRONT,
				deq_pkg::OP_PUSH_REAR:  status_q <= is_full ? deq_pkg::ST_FULL : deq_pkg::ST_OK;
				deq_pkg::OP_POP_FRONT,
				deq_pkg::OP_POP_REAR:   status_q <= is_empty ? deq_pkg::ST_EMPTY
					: deq_pkg::ST_OK;
				deq_pkg::OP_SEARCH:     status_q <= deq_pkg::ST_NOT_FOUND;
				default:                status_q <= deq_pkg::ST_OK;
			endcase
		end else if (state_q == S_WAIT) begin
			popped_q <= rd_data;
		end else if (state_q == S_SCAN) begin
			if (hit) begin
				status_q <= deq_pkg::ST_OK;
				found_q  <= idx_q;
			end else begin
				idx_q <= PTR_W'(idx_next);
			end
		end
	end

	// result word
	assign res_valid       = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.value_out   = deq_pkg::VAL_W'(popped_q);
	assign res.found_index = deq_pkg::IDX_W'(found_q);
	assign res.count       = deq_pkg::COUNT_W'(occ_q);
	assign res.is_empty    = is_empty;

endmodule

// ----- design/double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core: double-ended queue on a ring buffer
// Push and pop at either end, search from the front, one response word
// per command word, held in an output register.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake       payload
//  cmd       in    valid / ready   opcode, value
//  rsp       out   valid / ready   status, value_out, found_index, count, is_empty
//
// Push and unused opcodes pass from accept through S_DONE to the output register;
// a pop that finds an entry goes through S_WAIT first (one registered storage read),
// a search on a non-empty queue stays in S_SCAN while it compares entries, at most the count held.
// The search walks one entry per cycle through the single storage read port.
// Reset empties the queue at once; storage contents need no clearing.
// A stalled rsp keeps its word; cmd is taken again once the sequencer is idle.

module double_ended_queue_core #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	parameter int WIDTH = deq_pkg::WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	deq_cmd_if.sink       cmd,
	deq_rsp_if.source     rsp
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	logic [WIDTH-1:0] wr_data;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic [WIDTH-1:0] rd_data;

	logic             res_valid;
	logic             res_ready;
	deq_pkg::res_t    res;

	deq_pkg::res_t    out_q;
	logic             out_valid_q;

	// storage
	deq_mem #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer
	deq_ctrl #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.opcode    (cmd.opcode),
		.value     (cmd.value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// output register
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.value_out   = out_q.value_out;
	assign rsp.found_index = out_q.found_index;
	assign rsp.count       = out_q.count;
	assign rsp.is_empty    = out_q.is_empty;

endmodule
